FILE: hdl/uerb_pkg.sv
// shared types, constants and pointer helpers for the uart echo ring buffers
package uerb_pkg;

    // fifo depths, one slot of each always stays empty
    localparam int RX_DEPTH = 256;
    localparam int TX_DEPTH = 256;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);

    // character codes
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // event codes
    typedef enum logic [1:0] {
        OP_RX_BYTE   = 2'd0,
        OP_TX_READY  = 2'd1,
        OP_ECHO_POLL = 2'd2,
        OP_UNUSED    = 2'd3
    } t_opcode;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RX_PUSH,
        S_TX_FETCH,
        S_TX_POP,
        S_RX_FETCH,
        S_ECHO_PUSH,
        S_LF_PUSH,
        S_DONE
    } t_state;

    typedef logic [RX_AW-1:0] t_rx_ptr;
    typedef logic [TX_AW-1:0] t_tx_ptr;

    // one input event
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    // one result
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_irq_enable;
        logic       rx_dropped;
        logic [1:0] echo_dropped;
        logic [7:0] rx_level;
        logic [7:0] tx_level;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic rx_push;
        logic tx_fetch;
        logic tx_pop;
        logic rx_fetch;
        logic echo_push;
        logic lf_push;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic rx_empty;
        logic rx_is_cr;
    } t_dp_status;

    // pointer advance with wrap
    function automatic t_rx_ptr rx_ptr_inc(input t_rx_ptr p);
        t_rx_ptr r;
        if (p == RX_AW'(RX_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + RX_AW'(1);
        end
        return r;
    endfunction

    function automatic t_tx_ptr tx_ptr_inc(input t_tx_ptr p);
        t_tx_ptr r;
        if (p == TX_AW'(TX_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + TX_AW'(1);
        end
        return r;
    endfunction

    // fill level from write and read pointers
    function automatic logic [7:0] rx_count(input t_rx_ptr wr, input t_rx_ptr rd);
        logic [RX_AW:0] d;
        if (wr >= rd) begin
            d = {1'b0, wr} - {1'b0, rd};
        end else begin
            d = {1'b0, wr} + (RX_AW + 1)'(RX_DEPTH) - {1'b0, rd};
        end
        return 8'(d);
    endfunction

    function automatic logic [7:0] tx_count(input t_tx_ptr wr, input t_tx_ptr rd);
        logic [TX_AW:0] d;
        if (wr >= rd) begin
            d = {1'b0, wr} - {1'b0, rd};
        end else begin
            d = {1'b0, wr} + (TX_AW + 1)'(TX_DEPTH) - {1'b0, rd};
        end
        return 8'(d);
    endfunction

endpackage

FILE: hdl/uerb_ctrl.sv
// sequencing state machine for the uart echo ring buffers
module uerb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_opcode,
    input  uerb_pkg::t_dp_status  i_status,
    output uerb_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    uerb_pkg::t_state r_state;
    uerb_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uerb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            uerb_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        uerb_pkg::OP_RX_BYTE:   n_state = uerb_pkg::S_RX_PUSH;
                        uerb_pkg::OP_TX_READY:  n_state = uerb_pkg::S_TX_FETCH;
                        uerb_pkg::OP_ECHO_POLL: n_state = uerb_pkg::S_RX_FETCH;
                        default:                n_state = uerb_pkg::S_DONE;
                    endcase
                end
            end
            uerb_pkg::S_RX_PUSH:  n_state = uerb_pkg::S_DONE;
            uerb_pkg::S_TX_FETCH: n_state = uerb_pkg::S_TX_POP;
            uerb_pkg::S_TX_POP:   n_state = uerb_pkg::S_DONE;
            uerb_pkg::S_RX_FETCH: n_state = uerb_pkg::S_ECHO_PUSH;
            uerb_pkg::S_ECHO_PUSH: begin
                // a popped carriage return also queues a line feed
                if (!i_status.rx_empty && i_status.rx_is_cr) begin
                    n_state = uerb_pkg::S_LF_PUSH;
                end else begin
                    n_state = uerb_pkg::S_DONE;
                end
            end
            uerb_pkg::S_LF_PUSH: n_state = uerb_pkg::S_DONE;
            uerb_pkg::S_DONE:    n_state = uerb_pkg::S_IDLE;
            default:             n_state = uerb_pkg::S_IDLE;
        endcase
    end

    // command and handshake outputs
    always_comb begin
        o_cmd           = '0;
        o_busy          = 1'b1;
        o_done          = 1'b0;
        case (r_state)
            uerb_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            uerb_pkg::S_RX_PUSH:   o_cmd.rx_push   = 1'b1;
            uerb_pkg::S_TX_FETCH:  o_cmd.tx_fetch  = 1'b1;
            uerb_pkg::S_TX_POP:    o_cmd.tx_pop    = 1'b1;
            uerb_pkg::S_RX_FETCH:  o_cmd.rx_fetch  = 1'b1;
            uerb_pkg::S_ECHO_PUSH: o_cmd.echo_push = 1'b1;
            uerb_pkg::S_LF_PUSH:   o_cmd.lf_push   = 1'b1;
            uerb_pkg::S_DONE:      o_done          = 1'b1;
            default:               o_busy          = 1'b1;
        endcase
    end

endmodule

FILE: hdl/uerb_dp.sv
// fifo stores, pointers, interrupt flag and result registers
module uerb_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uerb_pkg::t_dp_cmd     i_cmd,
    input  logic [7:0]            i_rx_byte,
    output uerb_pkg::t_dp_status  o_status,
    output uerb_pkg::t_out_item   o_result
);

    // byte stores
    logic [7:0] rx_mem [uerb_pkg::RX_DEPTH];
    logic [7:0] tx_mem [uerb_pkg::TX_DEPTH];

    uerb_pkg::t_rx_ptr r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    uerb_pkg::t_tx_ptr r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic              r_flag, n_flag;

    logic [7:0] r_rx_rdata;
    logic [7:0] r_tx_rdata;
    logic [7:0] r_rx_byte, n_rx_byte;
    logic       r_tx_valid, n_tx_valid;
    logic [7:0] r_tx_byte, n_tx_byte;
    logic       r_rx_drop, n_rx_drop;
    logic [1:0] r_echo_drop, n_echo_drop;

    logic       rx_we;
    logic       tx_we;
    logic [7:0] tx_wdata;
    logic       rx_full, rx_empty, tx_full, tx_empty;

    // fifo occupancy
    assign rx_full  = (uerb_pkg::rx_ptr_inc(r_rx_wr) == r_rx_rd);
    assign rx_empty = (r_rx_wr == r_rx_rd);
    assign tx_full  = (uerb_pkg::tx_ptr_inc(r_tx_wr) == r_tx_rd);
    assign tx_empty = (r_tx_wr == r_tx_rd);

    // next values for each command
    always_comb begin
        n_rx_wr     = r_rx_wr;
        n_rx_rd     = r_rx_rd;
        n_tx_wr     = r_tx_wr;
        n_tx_rd     = r_tx_rd;
        n_flag      = r_flag;
        n_rx_byte   = r_rx_byte;
        n_tx_valid  = r_tx_valid;
        n_tx_byte   = r_tx_byte;
        n_rx_drop   = r_rx_drop;
        n_echo_drop = r_echo_drop;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        tx_wdata    = r_rx_rdata;
        if (i_cmd.load) begin
            n_rx_byte   = i_rx_byte;
            n_tx_valid  = 1'b0;
            n_tx_byte   = '0;
            n_rx_drop   = 1'b0;
            n_echo_drop = '0;
        end
        // received byte into the receive fifo
        if (i_cmd.rx_push) begin
            if (rx_full) begin
                n_rx_drop = 1'b1;
            end else begin
                rx_we   = 1'b1;
                n_rx_wr = uerb_pkg::rx_ptr_inc(r_rx_wr);
            end
            if (tx_empty) begin
                n_flag = 1'b0;
            end
        end
        // send the oldest transmit byte
        if (i_cmd.tx_pop) begin
            if (!tx_empty) begin
                n_tx_valid = 1'b1;
                n_tx_byte  = r_tx_rdata;
                n_tx_rd    = uerb_pkg::tx_ptr_inc(r_tx_rd);
                if (uerb_pkg::tx_ptr_inc(r_tx_rd) == r_tx_wr) begin
                    n_flag = 1'b0;
                end
            end else begin
                n_flag = 1'b0;
            end
        end
        // move one byte from receive to transmit
        if (i_cmd.echo_push && !rx_empty) begin
            n_rx_rd = uerb_pkg::rx_ptr_inc(r_rx_rd);
            if (tx_full) begin
                n_echo_drop = r_echo_drop + 2'd1;
            end else begin
                tx_we    = 1'b1;
                tx_wdata = r_rx_rdata;
                n_tx_wr  = uerb_pkg::tx_ptr_inc(r_tx_wr);
                n_flag   = 1'b1;
            end
        end
        // line feed after a carriage return
        if (i_cmd.lf_push) begin
            if (tx_full) begin
                n_echo_drop = r_echo_drop + 2'd1;
            end else begin
                tx_we    = 1'b1;
                tx_wdata = uerb_pkg::CHAR_LF;
                n_tx_wr  = uerb_pkg::tx_ptr_inc(r_tx_wr);
                n_flag   = 1'b1;
            end
        end
    end

    // pointers and flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr <= '0;
            r_rx_rd <= '0;
            r_tx_wr <= '0;
            r_tx_rd <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_rx_wr <= n_rx_wr;
            r_rx_rd <= n_rx_rd;
            r_tx_wr <= n_tx_wr;
            r_tx_rd <= n_tx_rd;
            r_flag  <= n_flag;
        end
    end

    // item and result registers
    always_ff @(posedge i_clk) begin
        r_rx_byte   <= n_rx_byte;
        r_tx_valid  <= n_tx_valid;
        r_tx_byte   <= n_tx_byte;
        r_rx_drop   <= n_rx_drop;
        r_echo_drop <= n_echo_drop;
    end

    // receive store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            rx_mem[r_rx_wr] <= r_rx_byte;
        end
        if (i_cmd.rx_fetch) begin
            r_rx_rdata <= rx_mem[r_rx_rd];
        end
    end

    // transmit store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            tx_mem[r_tx_wr] <= tx_wdata;
        end
        if (i_cmd.tx_fetch) begin
            r_tx_rdata <= tx_mem[r_tx_rd];
        end
    end

    // status back to the controller
    assign o_status.rx_empty = rx_empty;
    assign o_status.rx_is_cr = (r_rx_rdata == uerb_pkg::CHAR_CR);

    // result fields
    assign o_result.tx_valid      = r_tx_valid;
    assign o_result.tx_byte       = r_tx_byte;
    assign o_result.tx_irq_enable = r_flag;
    assign o_result.rx_dropped    = r_rx_drop;
    assign o_result.echo_dropped  = r_echo_drop;
    assign o_result.rx_level      = uerb_pkg::rx_count(r_rx_wr, r_rx_rd);
    assign o_result.tx_level      = uerb_pkg::tx_count(r_tx_wr, r_tx_rd);

endmodule

FILE: hdl/uart_echo_ring_buffers_unit.sv
// top level of the uart echo ring buffers: controller plus datapath
//
// An event is taken when start is high and busy is low; its result appears on
// o_result for one cycle with o_done high, and must be taken in that cycle.
// A received byte is pushed; transmitter ready fetches, then pops; an echo
// poll fetches, then pushes the echo, plus a line feed for a carriage return;
// the unused opcode goes to the result. The order is set by the registered
// read port of each byte store (a fetch state before a pop) and the single
// write port of the transmit store (one push per cycle), plus a result state.
// Both stores come up with unknown contents and need no clearing.
module uart_echo_ring_buffers_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  uerb_pkg::t_in_item   i_cmd,
    output logic                 busy,
    output logic                 o_done,
    output uerb_pkg::t_out_item  o_result
);

    uerb_pkg::t_dp_cmd    dp_cmd;
    uerb_pkg::t_dp_status dp_status;

    // sequencer
    uerb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_cmd.opcode),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // fifos and result registers
    uerb_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_rx_byte (i_cmd.rx_byte),
        .o_status  (dp_status),
        .o_result  (o_result)
    );

endmodule

FILE: hdl/uerb_checker.sv
// port level checks for the uart echo ring buffers, bound to the top level
module uerb_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input uerb_pkg::t_out_item  o_result
);

    // an accepted event makes the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a transfer");

    // the result cycle is followed by a return to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("block still busy after result");

    // no byte sent means a zero byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.tx_valid) |-> (o_result.tx_byte == 8'd0))
        else $error("nonzero byte without a send");

    // a dropped received byte means the receive fifo is full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.rx_dropped) |->
            (o_result.rx_level == 8'(uerb_pkg::RX_DEPTH - 1)))
        else $error("receive drop while fifo not full");

endmodule

bind uart_echo_ring_buffers_unit uerb_checker u_uerb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
